// ===== rtl/b2d_pkg.sv =====
// shared constants, state types and the double-dabble step for the binary to decimal converter
package b2d_pkg;

  // binary value
  localparam int VALUE_WIDTH = 64;
  localparam int IN_WIDTH    = 64;
  localparam int PAD_WIDTH   = ((VALUE_WIDTH + 3) / 4) * 4;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS       = PAD_WIDTH / BITS_PER_STEP;
  localparam int STEP_CNT_W  = $clog2(STEPS + 1);

  // decimal digits
  localparam int MAX_DIGITS  = 20;
  localparam int BCD_W       = MAX_DIGITS * 4;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int CHAR_W      = 6;
  localparam int OUT_TDATA_W = 8;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // queue between converter and emitter
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_BUSY,
    FRONT_DONE
  } front_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // one shift-add-3 step: fix up every digit, then shift in one binary bit
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic in_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], in_bit};
  endfunction

endpackage

// ===== rtl/b2d_conv.sv =====
// front end: accepts a binary word and converts it to packed bcd, four bits per cycle
module b2d_conv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [b2d_pkg::IN_WIDTH-1:0]    in_value,
  output logic                            push,
  output logic [b2d_pkg::BCD_W-1:0]       push_data,
  input  b2d_pkg::fifo_status_t           fifo_status
);

  b2d_pkg::front_state_t state_r, state_nxt;

  logic [b2d_pkg::PAD_WIDTH-1:0]  bin_r;
  logic [b2d_pkg::BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [b2d_pkg::STEP_CNT_W-1:0] cnt_r;
  logic                           last_step;

  assign last_step = (cnt_r == b2d_pkg::STEP_CNT_W'(b2d_pkg::STEPS - 1));

  // four chained shift-add-3 steps
  always_comb begin
    bcd_nxt = bcd_r;
    for (int b = 0; b < b2d_pkg::BITS_PER_STEP; b++) begin
      bcd_nxt = b2d_pkg::dd_step(bcd_nxt, bin_r[b2d_pkg::PAD_WIDTH-1-b]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b2d_pkg::FRONT_IDLE: begin
        if (in_tvalid) state_nxt = b2d_pkg::FRONT_BUSY;
      end
      b2d_pkg::FRONT_BUSY: begin
        if (last_step) state_nxt = b2d_pkg::FRONT_DONE;
      end
      b2d_pkg::FRONT_DONE: begin
        if (!fifo_status.full) state_nxt = b2d_pkg::FRONT_IDLE;
      end
      default: state_nxt = b2d_pkg::FRONT_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    push      = 1'b0;
    case (state_r)
      b2d_pkg::FRONT_IDLE: in_tready = 1'b1;
      b2d_pkg::FRONT_DONE: push = !fifo_status.full;
      default: ;
    endcase
  end

  assign push_data = bcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2d_pkg::FRONT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      bin_r <= b2d_pkg::PAD_WIDTH'(in_value[b2d_pkg::VALUE_WIDTH-1:0]);
      bcd_r <= '0;
      cnt_r <= '0;
    end else if (state_r == b2d_pkg::FRONT_BUSY) begin
      bin_r <= bin_r << b2d_pkg::BITS_PER_STEP;
      bcd_r <= bcd_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ===== rtl/b2d_fifo.sv =====
// short queue of converted bcd words between front and back
module b2d_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [b2d_pkg::BCD_W-1:0]   push_data,
  input  logic                        pop,
  output logic [b2d_pkg::BCD_W-1:0]   pop_data,
  output b2d_pkg::fifo_status_t       status
);

  logic [b2d_pkg::BCD_W-1:0]      mem_r [b2d_pkg::FIFO_DEPTH];
  logic [b2d_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [b2d_pkg::FIFO_CNT_W-1:0] count_r;

  assign status.full  = (count_r == b2d_pkg::FIFO_CNT_W'(b2d_pkg::FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == b2d_pkg::FIFO_PTR_W'(b2d_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == b2d_pkg::FIFO_PTR_W'(b2d_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/b2d_emit.sv =====
// back end: walks the bcd digits from the top, drops leading zeros, drives the output register
module b2d_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  output logic                              pop,
  input  logic [b2d_pkg::BCD_W-1:0]         pop_data,
  input  b2d_pkg::fifo_status_t             fifo_status,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [b2d_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  b2d_pkg::back_state_t state_r, state_nxt;

  logic [b2d_pkg::BCD_W-1:0]       digits_r;
  logic [b2d_pkg::DIGIT_IDX_W-1:0] idx_r;
  logic                            started_r;
  logic                            out_valid_r;
  logic [b2d_pkg::CHAR_W-1:0]      out_char_r;
  logic                            out_last_r;

  logic [3:0] top_digit;
  logic       last_pos;
  logic       emit;
  logic       step_go;

  assign top_digit = digits_r[b2d_pkg::BCD_W-1 -: 4];
  assign last_pos  = (idx_r == b2d_pkg::DIGIT_IDX_W'(b2d_pkg::MAX_DIGITS - 1));
  assign emit      = started_r || (top_digit != 4'd0) || last_pos;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b2d_pkg::BACK_IDLE: begin
        if (!fifo_status.empty) state_nxt = b2d_pkg::BACK_RUN;
      end
      b2d_pkg::BACK_RUN: begin
        if (step_go && last_pos) state_nxt = b2d_pkg::BACK_IDLE;
      end
      default: state_nxt = b2d_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    step_go = 1'b0;
    case (state_r)
      b2d_pkg::BACK_IDLE: pop = !fifo_status.empty;
      b2d_pkg::BACK_RUN:  step_go = !emit || !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = b2d_pkg::OUT_TDATA_W'(out_char_r);
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2d_pkg::BACK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (step_go && emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digits_r  <= pop_data;
      idx_r     <= '0;
      started_r <= 1'b0;
    end else if (step_go) begin
      digits_r  <= digits_r << 4;
      idx_r     <= idx_r + 1'b1;
      started_r <= emit;
    end
    if (step_go && emit) begin
      out_char_r <= b2d_pkg::CHAR_W'(top_digit) + b2d_pkg::ASCII_ZERO;
      out_last_r <= last_pos;
    end
  end

endmodule

// ===== rtl/binary_to_decimal_digits.sv =====
// top level: unsigned binary word in, ascii decimal digits out, most significant first
// order: load, shift-add-3 steps of four bits each, a push into the queue, a pop into the
//   emitter, then one digit position per cycle while the output is not stalled (20 positions,
//   leading zeros take a position step but give no word)
// pacing: set by the emitter (one pop plus 20 digit positions per value); the converter runs
//   ahead through the queue and can take the next value while the emitter is still busy
// reset: rst_n synchronous, active low; clears both state machines, the queue and out_tvalid
module binary_to_decimal_digits (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic        out_tlast   // last_digit
);

  // handoff between converter and queue
  logic                        push;
  logic [b2d_pkg::BCD_W-1:0]   push_data;
  // handoff between queue and emitter
  logic                        pop;
  logic [b2d_pkg::BCD_W-1:0]   pop_data;
  b2d_pkg::fifo_status_t       fifo_status;

  // front: binary to packed bcd, one value at a time
  b2d_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_value    (in_tdata),
    .push        (push),
    .push_data   (push_data),
    .fifo_status (fifo_status)
  );

  // two-entry queue so the converter can start the next value while digits go out
  b2d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (fifo_status)
  );

  // back: leading-zero suppression and the registered output word
  b2d_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .pop_data    (pop_data),
    .fifo_status (fifo_status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
